// ===== rtl/core/porwq_pkg.sv =====
// Shared types and constants for the resource wait queue.
// No dependencies.
package porwq_pkg;
   localparam int WAIT_SLOTS_DEF = 16;
   localparam int RESOURCES_DEF  = 8;
   localparam logic REQ_ENQ   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;
   localparam logic STAT_DONE = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [2:0] resource_index;
      logic [3:0] task_index;
      logic [7:0] enq_priority;
      logic [7:0] owner_base_priority;
      logic [7:0] owned_mask;
   } req_type_t_type;

   typedef struct packed {
      logic       status;
      logic [3:0] head_task;
      logic [7:0] head_priority;
      logic [4:0] waiter_count;
      logic [7:0] inherited_priority;
   } rsp_type_t_type;

   // one waiter as kept in a cell
   typedef struct packed {
      logic       used;
      logic [3:0] task_id;
      logic [7:0] prio;
   } entry_type;

   // command broadcast along the chain of one resource
   typedef struct packed {
      logic       ins;
      logic [3:0] task_id;
      logic [7:0] prio;
   } cmd_type;
endpackage

// ===== rtl/core/porwq_if.sv =====
// Valid/ready channel carrying a packed payload.
// Depends on nothing; payload type given as parameter.
interface porwq_if #(parameter type T = logic) (input logic clock);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/porwq_cell.sv =====
// One sorted-list cell: holds a waiter, shifts down on insert.
// Depends on porwq_pkg.
module porwq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  porwq_pkg::cmd_type   cmd,
   input  porwq_pkg::entry_type up_entry,
   input  logic                 up_shift,
   output porwq_pkg::entry_type entry,
   output logic                 shift
);
   porwq_pkg::entry_type entry_ff, entry_in;
   logic take_new;

   // a new waiter goes behind every stored one of at least its priority;
   // only the first cell past the occupied ones of higher or equal priority takes it
   assign shift    = entry_ff.used && (entry_ff.prio < cmd.prio);
   assign take_new = !up_shift && up_entry.used && (shift || !entry_ff.used);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (up_shift) entry_in = up_entry;
         else if (take_new) begin
            entry_in.used    = 1'b1;
            entry_in.task_id = cmd.task_id;
            entry_in.prio    = cmd.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff.used <= 1'b0;
      else       entry_ff.used <= entry_in.used;
      entry_ff.task_id <= entry_in.task_id;
      entry_ff.prio    <= entry_in.prio;
   end
endmodule

// ===== rtl/core/porwq_chain.sv =====
// Chain of cells for one resource, head at cell 0, plus waiter count.
// Depends on porwq_pkg and porwq_cell.
module porwq_chain #(
   parameter int WAIT_SLOTS = porwq_pkg::WAIT_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  porwq_pkg::cmd_type   cmd,
   output porwq_pkg::entry_type head,
   output logic                 full,
   output logic [4:0]           count
);
   // the head cell sees an occupied neighbor above it that never shifts
   localparam porwq_pkg::entry_type TOP_ENTRY = '{used: 1'b1, task_id: 4'd0, prio: 8'd0};

   porwq_pkg::entry_type ent [WAIT_SLOTS];
   logic [WAIT_SLOTS-1:0] sh;
   logic [4:0] count_ff, count_in;
   porwq_pkg::cmd_type cmd_g;

   assign full  = ent[WAIT_SLOTS-1].used;
   assign cmd_g = '{ins: cmd.ins && !full, task_id: cmd.task_id, prio: cmd.prio};

   for (genvar i = 0; i < WAIT_SLOTS; i++) begin : g_cell
      porwq_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd_g),
         .up_entry(i == 0 ? TOP_ENTRY : ent[(i == 0) ? 0 : i-1]),
         .up_shift(i == 0 ? 1'b0 : sh[(i == 0) ? 0 : i-1]),
         .entry(ent[i]), .shift(sh[i])
      );
   end

   assign head  = ent[0];
   assign count = count_ff;
   assign count_in = cmd_g.ins ? count_ff + 5'd1 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end
endmodule

// ===== rtl/core/priority_ordered_resource_wait_queue_unit.sv =====
// Top level of the resource wait queue; one cell chain per resource.
// Depends on porwq_pkg, porwq_if, porwq_chain.
//
// Usage: req carries enqueue or query items, rsp returns one item each.
// Each resource keeps its waiters in a row of cells sorted by priority,
// head first; in the ENQ state an enqueue shifts the lower waiters down one cell,
// in SCAN the new head and count are read (an out-of-range resource skips
// SCAN) and OUT presents the result from the output register. A query
// scans all resources one per cycle, keeping the highest owned head
// priority above the owner base priority. One item is in work at a time;
// the next item is taken the cycle after the result is accepted.
// A full list drops the enqueue and reports status full.
// Reset empties every list. While rsp is stalled the result is held and
// no new item is taken.
module priority_ordered_resource_wait_queue_unit #(
   parameter int WAIT_SLOTS = porwq_pkg::WAIT_SLOTS_DEF,
   parameter int RESOURCES  = porwq_pkg::RESOURCES_DEF
) (
   input  logic clock,
   input  logic reset,
   porwq_if.sink   req,
   porwq_if.source rsp
);
   localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_ENQ = 4'b0010, S_SCAN = 4'b0100, S_OUT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   porwq_pkg::req_type_t_type rq_ff, rq_in;
   porwq_pkg::rsp_type_t_type out_ff, out_in;
   logic [RW-1:0] idx_ff, idx_in;
   logic [7:0] best_ff, best_in;

   porwq_pkg::cmd_type   cmd   [RESOURCES];
   porwq_pkg::entry_type heads [RESOURCES];
   logic                 fulls [RESOURCES];
   logic [4:0]           cnts  [RESOURCES];

   logic in_range;
   assign in_range = 32'(rq_ff.resource_index) < RESOURCES;

   for (genvar r = 0; r < RESOURCES; r++) begin : g_res
      assign cmd[r] = '{ins: state_ff == S_ENQ && in_range &&
                             rq_ff.resource_index == 3'(r),
                        task_id: rq_ff.task_index, prio: rq_ff.enq_priority};
      porwq_chain #(.WAIT_SLOTS(WAIT_SLOTS)) u_chain (
         .clock(clock), .reset(reset), .cmd(cmd[r]),
         .head(heads[r]), .full(fulls[r]), .count(cnts[r]));
   end

   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = state_ff == S_OUT;
   assign rsp.data  = out_ff;

   logic [RW-1:0] ri;
   assign ri = RW'(rq_ff.resource_index);

   always_comb begin
      state_in = state_ff;
      rq_in = rq_ff; out_in = out_ff; idx_in = idx_ff; best_in = best_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid) begin
            rq_in = req.data;
            idx_in = '0;
            best_in = req.data.owner_base_priority;
            state_in = (req.data.req_type == porwq_pkg::REQ_QUERY) ? S_SCAN : S_ENQ;
         end
         S_ENQ: begin
            // chain updates this cycle; report from the next one
            out_in = '0;
            if (in_range && fulls[ri]) out_in.status = porwq_pkg::STAT_FULL;
            state_in = in_range ? S_OUT : S_OUT;
            if (in_range) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (rq_ff.req_type == porwq_pkg::REQ_ENQ) begin
               if (heads[ri].used) begin
                  out_in.head_task     = heads[ri].task_id;
                  out_in.head_priority = heads[ri].prio;
               end
               out_in.waiter_count = cnts[ri];
               state_in = S_OUT;
            end else begin
               if (32'(idx_ff) < 8 && rq_ff.owned_mask[3'(idx_ff)] &&
                   heads[idx_ff].used && heads[idx_ff].prio > best_ff)
                  best_in = heads[idx_ff].prio;
               if (32'(idx_ff) == RESOURCES-1) begin
                  out_in = '0;
                  out_in.inherited_priority =
                     (32'(idx_ff) < 8 && rq_ff.owned_mask[3'(idx_ff)] &&
                      heads[idx_ff].used && heads[idx_ff].prio > best_ff)
                     ? heads[idx_ff].prio : best_ff;
                  state_in = S_OUT;
               end else idx_in = idx_ff + RW'(1);
            end
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
      rq_ff <= rq_in; out_ff <= out_in; idx_ff <= idx_in; best_ff <= best_in;
   end
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the resource wait queue: enqueue and inherited-priority query items.
// Depends on porwq_pkg, porwq_if and priority_ordered_resource_wait_queue_unit.
// Checks each result against a behavioral copy of the wait lists.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = porwq_pkg::WAIT_SLOTS_DEF;
   localparam int NRES  = porwq_pkg::RESOURCES_DEF;

   logic clock;
   logic reset;

   porwq_if #(.T(porwq_pkg::req_type_t_type)) req (clock);
   porwq_if #(.T(porwq_pkg::rsp_type_t_type)) rsp (clock);

   priority_ordered_resource_wait_queue_unit dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );

   // per-resource waiter lists, head first, arrival order kept among equals
   logic [3:0] wl_task [NRES][$];
   logic [7:0] wl_prio [NRES][$];

   porwq_pkg::req_type_t_type pending_reqs[$];
   porwq_pkg::rsp_type_t_type expected_rsps[$];
   bit failed = 0;
   bit stim_done = 0;
   bit hold_long = 0;

   function automatic porwq_pkg::rsp_type_t_type wait_queue_predict(
      porwq_pkg::req_type_t_type it);
      porwq_pkg::rsp_type_t_type o;
      int r, pos;
      o = '0;
      if (it.req_type == porwq_pkg::REQ_QUERY) begin
         o.inherited_priority = it.owner_base_priority;
         for (int i = 0; i < NRES; i++)
            if (it.owned_mask[i] && wl_prio[i].size() > 0 &&
                wl_prio[i][0] > o.inherited_priority)
               o.inherited_priority = wl_prio[i][0];
         return o;
      end
      r = int'(it.resource_index);
      if (r >= NRES) return o;
      if (wl_prio[r].size() >= NSLOT) begin
         o.status = porwq_pkg::STAT_FULL;
      end else begin
         pos = 0;
         while (pos < wl_prio[r].size() && wl_prio[r][pos] >= it.enq_priority) pos++;
         wl_prio[r].insert(pos, it.enq_priority);
         wl_task[r].insert(pos, it.task_index);
         o.status = porwq_pkg::STAT_DONE;
      end
      o.head_task = wl_task[r][0];
      o.head_priority = wl_prio[r][0];
      o.waiter_count = 5'(wl_prio[r].size());
      return o;
   endfunction

   function automatic porwq_pkg::req_type_t_type make_enq(int r, int t, int p);
      porwq_pkg::req_type_t_type it;
      it.owner_base_priority = 8'($urandom);
      it.owned_mask = 8'($urandom);
      it.req_type = porwq_pkg::REQ_ENQ;
      it.resource_index = 3'(r);
      it.task_index = 4'(t);
      it.enq_priority = 8'(p);
      return it;
   endfunction

   function automatic porwq_pkg::req_type_t_type make_query(int b, int m);
      porwq_pkg::req_type_t_type it;
      it.resource_index = 3'($urandom);
      it.task_index = 4'($urandom);
      it.enq_priority = 8'($urandom);
      it.req_type = porwq_pkg::REQ_QUERY;
      it.owner_base_priority = 8'(b);
      it.owned_mask = 8'(m);
      return it;
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // stimulus: directed part, then random; nothing removes waiters, so
   // random traffic soon fills every list and later enqueues hit the full path
   initial begin
      int n;
      pending_reqs.push_back(make_query(0, 8'hFF));
      pending_reqs.push_back(make_query(255, 0));
      pending_reqs.push_back(make_enq(0, 0, 0));
      pending_reqs.push_back(make_enq(0, 15, 255));
      pending_reqs.push_back(make_enq(0, 5, 255));
      pending_reqs.push_back(make_enq(0, 6, 0));
      pending_reqs.push_back(make_enq(7, 10, 128));
      pending_reqs.push_back(make_query(0, 8'h81));
      pending_reqs.push_back(make_query(255, 8'hFF));
      pending_reqs.push_back(make_query(100, 8'h7E));
      for (int i = 0; i < 14; i++)
         pending_reqs.push_back(make_enq(3, i, 50 + (i % 3)));
      pending_reqs.push_back(make_query(0, 8'h08));
      n = 0;
      while (n < 1400) begin
         int r;
         r = $urandom_range(0, 7);
         if ($urandom_range(0, 2) == 0)
            pending_reqs.push_back(make_query($urandom_range(0, 255), $urandom_range(0, 255)));
         else if ($urandom_range(0, 3) == 0)
            pending_reqs.push_back(make_enq(r, $urandom_range(0, 15),
                                            $urandom_range(0, 3) * 85));
         else
            pending_reqs.push_back(make_enq(r, $urandom_range(0, 15),
                                            $urandom_range(0, 255)));
         n++;
      end
      stim_done = 1;
   end

   // driver
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.data <= '0;
         send_gap <= 0;
      end else if (req.valid && !req.ready) begin
         // hold the offered item
      end else if (send_gap > 0) begin
         req.valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         req.valid <= 1'b1;
         req.data <= pending_reqs.pop_front();
         send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
      end else begin
         req.valid <= 1'b0;
      end
   end

   // accept side: predict at the input handshake
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         expected_rsps.push_back(wait_queue_predict(req.data));
   end

   // monitor and receiver stalls
   int stall_cnt;
   int rsp_count = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_cnt <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            porwq_pkg::rsp_type_t_type e;
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp.data);
               failed = 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp.data !== e) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp.data);
                  failed = 1;
               end
            end
         end
         // long hold-off once, so the input backs up
         if (rsp_count == 300 && !hold_long) begin
            hold_long <= 1;
            rsp.ready <= 1'b0;
            stall_cnt <= 200;
         end else if (stall_cnt > 0) begin
            rsp.ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
         end else if (rsp.ready && rsp.valid && $urandom_range(0, 3) == 0) begin
            rsp.ready <= 1'b0;
            stall_cnt <= $urandom_range(0, 8);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1;
      repeat (12) @(posedge clock);
      reset <= 0;
      wait (stim_done && pending_reqs.size() == 0 && !req.valid);
      wait (expected_rsps.size() == 0);
      repeat (40) @(posedge clock);
      if (!failed && expected_rsps.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   initial begin
      #4ms;
      $display("tb_top failed");
      $finish;
   end
endmodule

// ===== priority_ordered_resource_wait_queue_unit.f =====
rtl/core/porwq_pkg.sv
rtl/core/porwq_if.sv
rtl/core/porwq_cell.sv
rtl/core/porwq_chain.sv
rtl/core/priority_ordered_resource_wait_queue_unit.sv
tb/sv/tb_top.sv
